// ===== sv/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the heightfield sampler
// Field widths, item kinds, register indexes and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  localparam int FX_W   = 32;   // Q16.16 words
  localparam int SIZE_W = 31;   // chunk_size register
  localparam int RES_W  = 7;    // grid_resolution register
  localparam int TILE_W = 16;   // tile chunk coordinates
  localparam int IDX_W  = 6;    // grid_col / grid_row input fields
  localparam int LX_W   = 31;   // local offset inside the tile
  localparam int M_W    = LX_W + RES_W;  // local offset times (res - 1)
  localparam int CQ_W   = 16;   // chunk divider quotient bits
  localparam int GQ_W   = 16 + RES_W;    // grid divider quotient bits
  localparam int CX_W   = 18;   // signed chunk index

  localparam logic [FX_W-1:0] ONE_FX = 32'h0001_0000;

  // item kinds after classification
  localparam logic [1:0] KIND_WR   = 2'd0;
  localparam logic [1:0] KIND_MISS = 2'd1;
  localparam logic [1:0] KIND_HIT  = 2'd2;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_CHUNK_SIZE = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_GRID_RES   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_TILE_X     = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_TILE_Z     = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PRESENT    = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [FX_W-1:0]  height;
    logic [LX_W-1:0]  lx;
    logic [LX_W-1:0]  lz;
  } qent_t;

endpackage

`default_nettype wire

// ===== sv/hbs_ram.sv =====
// ----------------------------------------------------------------------------
// hbs_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                            wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [W-1:0]                            rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/hbs_div.sv =====
// ----------------------------------------------------------------------------
// hbs_div: pipelined restoring divider
// One quotient bit per stage; the user must hold the divisor static while items are in flight (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_div #(
  parameter int QW = 16,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          i_vld,
  input  wire logic [31:0]   i_rem,     // partial remainder, below divisor
  input  wire logic [QW-1:0] i_bits,    // dividend bits still to bring down
  input  wire logic [PW-1:0] i_pay,
  input  wire logic [31:0]   divisor,
  output logic               o_vld,
  output logic [QW-1:0]      o_quo,
  output logic [31:0]        o_rem,
  output logic [PW-1:0]      o_pay
);

  logic [QW-1:0] vld_r;
  logic [31:0]   rem_r [QW];
  logic [QW-1:0] sq_r  [QW];
  logic [PW-1:0] pay_r [QW];

  logic [31:0]   rin   [QW];
  logic [QW-1:0] sin   [QW];
  logic [PW-1:0] pin   [QW];
  logic [QW-1:0] vin;
  logic [31:0]   trial [QW];
  logic [QW-1:0] ge;

  always_comb begin
    rin[0] = i_rem;
    sin[0] = i_bits;
    pin[0] = i_pay;
    vin[0] = i_vld;
    for (int k = 1; k < QW; k++) begin
      rin[k] = rem_r[k-1];
      sin[k] = sq_r[k-1];
      pin[k] = pay_r[k-1];
      vin[k] = vld_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      trial[k] = {rin[k][30:0], sin[k][QW-1]};
      ge[k]    = (trial[k] >= divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= ge[k] ? (trial[k] - divisor) : trial[k];
        sq_r[k]  <= {sin[k][QW-2:0], ge[k]};
        pay_r[k] <= pin[k];
      end
    end
  end

  assign o_vld = vld_r[QW-1];
  assign o_quo = sq_r[QW-1];
  assign o_rem = rem_r[QW-1];
  assign o_pay = pay_r[QW-1];

endmodule

`default_nettype wire

// ===== sv/hbs_front.sv =====
// ----------------------------------------------------------------------------
// hbs_front: accept and classify items
// Finds the chunk of a query, checks it against the stored tile and pushes
// writes, misses and hits with their local offsets into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        func,
  input  wire logic [hbs_pkg::IDX_W-1:0]   grid_col,
  input  wire logic [hbs_pkg::IDX_W-1:0]   grid_row,
  input  wire logic [hbs_pkg::FX_W-1:0]    height_in,
  input  wire logic [hbs_pkg::FX_W-1:0]    world_x,
  input  wire logic [hbs_pkg::FX_W-1:0]    world_z,
  input  wire logic [hbs_pkg::SIZE_W-1:0]  chunk_size,
  input  wire logic [hbs_pkg::TILE_W-1:0]  tile_chunk_x,
  input  wire logic [hbs_pkg::TILE_W-1:0]  tile_chunk_z,
  input  wire logic                        tile_present,
  input  wire logic                        q_full,
  output logic                             q_push,
  output hbs_pkg::qent_t                   q_ent
);

  localparam int PXW = 2 + 2 * hbs_pkg::IDX_W + hbs_pkg::FX_W;

  typedef struct packed {
    logic signed [hbs_pkg::CX_W-1:0] cx;
    logic [hbs_pkg::LX_W-1:0]        lx;
  } fdiv_t;

  logic                          fe;
  logic                          acc;
  logic [31:0]                   size_eff;
  logic [31:0]                   ax;
  logic [31:0]                   az;
  logic                          vx;
  logic                          vz;
  logic [hbs_pkg::CQ_W-1:0]      qx;
  logic [hbs_pkg::CQ_W-1:0]      qz;
  logic [31:0]                   rx;
  logic [31:0]                   rz;
  logic [PXW-1:0]                px;
  logic                          pz;
  fdiv_t                         fx;
  fdiv_t                         fz;
  logic                          hit;

  // Floor correction of a magnitude division back to a signed chunk index
  // and a local offset in [0, size).
  function automatic fdiv_t floor_fix(input logic neg, input logic [hbs_pkg::CQ_W-1:0] qa,
                                      input logic [31:0] ra, input logic [31:0] sz);
    fdiv_t                    f;
    logic [hbs_pkg::CX_W-1:0] qe;
    qe = {2'b00, qa};
    if (!neg) begin
      f.cx = qe;
      f.lx = ra[hbs_pkg::LX_W-1:0];
    end else if (ra != 32'd0) begin
      f.cx = ~qe;
      f.lx = hbs_pkg::LX_W'(sz - ra);
    end else begin
      f.cx = ~qe + 1'b1;
      f.lx = '0;
    end
    return f;
  endfunction

  assign fe       = !q_full;
  assign in_ready = fe;
  assign acc      = in_valid && fe;

  assign size_eff = (chunk_size < hbs_pkg::SIZE_W'(hbs_pkg::ONE_FX)) ?
                    hbs_pkg::ONE_FX : {1'b0, chunk_size};
  assign ax = world_x[31] ? (~world_x + 32'd1) : world_x;
  assign az = world_z[31] ? (~world_z + 32'd1) : world_z;

  hbs_div #(.QW(hbs_pkg::CQ_W), .PW(PXW)) u_divx (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (fe),
    .i_vld   (acc),
    .i_rem   ({16'd0, ax[31:16]}),
    .i_bits  (ax[15:0]),
    .i_pay   ({world_x[31], func, grid_col, grid_row, height_in}),
    .divisor (size_eff),
    .o_vld   (vx),
    .o_quo   (qx),
    .o_rem   (rx),
    .o_pay   (px)
  );

  hbs_div #(.QW(hbs_pkg::CQ_W), .PW(1)) u_divz (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (fe),
    .i_vld   (acc),
    .i_rem   ({16'd0, az[31:16]}),
    .i_bits  (az[15:0]),
    .i_pay   (world_z[31]),
    .divisor (size_eff),
    .o_vld   (vz),
    .o_quo   (qz),
    .o_rem   (rz),
    .o_pay   (pz)
  );

  assign fx  = floor_fix(px[PXW-1], qx, rx, size_eff);
  assign fz  = floor_fix(pz, qz, rz, size_eff);
  assign hit = tile_present &&
               (fx.cx == {{2{tile_chunk_x[15]}}, tile_chunk_x}) &&
               (fz.cx == {{2{tile_chunk_z[15]}}, tile_chunk_z});

  always_comb begin
    q_ent.col    = px[hbs_pkg::FX_W+2*hbs_pkg::IDX_W-1:hbs_pkg::FX_W+hbs_pkg::IDX_W];
    q_ent.row    = px[hbs_pkg::FX_W+hbs_pkg::IDX_W-1:hbs_pkg::FX_W];
    q_ent.height = px[hbs_pkg::FX_W-1:0];
    q_ent.lx     = fx.lx;
    q_ent.lz     = fz.lx;
    if (!px[PXW-2]) begin
      q_ent.kind = hbs_pkg::KIND_WR;
    end else if (hit) begin
      q_ent.kind = hbs_pkg::KIND_HIT;
    end else begin
      q_ent.kind = hbs_pkg::KIND_MISS;
    end
  end

  assign q_push = vx && fe;

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n) vx == vz)
    else $error("x and z chunk dividers out of step");

endmodule

`default_nettype wire

// ===== sv/hbs_queue.sv =====
// ----------------------------------------------------------------------------
// hbs_queue: short queue between classification and sampling
// Register FIFO; the front stalls on full, the back drains at its own pace.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hbs_pkg::qent_t push_ent,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output hbs_pkg::qent_t      head
);

  hbs_pkg::qent_t             mem_r [hbs_pkg::QDEPTH];
  logic [hbs_pkg::QAW-1:0]    wp_r;
  logic [hbs_pkg::QAW-1:0]    rp_r;
  logic [hbs_pkg::QAW:0]      cnt_r;
  logic [hbs_pkg::QAW:0]      cnt_nxt;

  assign full  = (cnt_r == (hbs_pkg::QAW+1)'(hbs_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== sv/hbs_back.sv =====
// ----------------------------------------------------------------------------
// hbs_back: grid lookup and bilinear blend
// Scales the local offset to grid units, reads four corners from a banked
// store, blends along x then z, and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_back #(
  parameter int MAX_GRID = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [hbs_pkg::SIZE_W-1:0]  chunk_size,
  input  wire logic [hbs_pkg::RES_W-1:0]   grid_resolution,
  input  wire logic                        q_empty,
  input  wire hbs_pkg::qent_t              q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hbs_pkg::FX_W-1:0]         out_height,
  output logic                             out_hit
);

  localparam int HALF   = (MAX_GRID + 1) / 2;
  localparam int BDEPTH = HALF * HALF;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int PXW    = 2 + 2 * hbs_pkg::IDX_W;

  logic                            be;
  logic [31:0]                     size_eff;
  logic [hbs_pkg::RES_W-1:0]       resm1;

  // s0: popped entry, offsets scaled by (res - 1)
  logic                            v0_r;
  logic [1:0]                      k0_r;
  logic [hbs_pkg::IDX_W-1:0]       col0_r;
  logic [hbs_pkg::IDX_W-1:0]       row0_r;
  logic [hbs_pkg::FX_W-1:0]        hgt0_r;
  logic [hbs_pkg::M_W-1:0]         mx_r;
  logic [hbs_pkg::M_W-1:0]         mz_r;

  // grid dividers
  logic                            vx;
  logic                            vz;
  logic [hbs_pkg::GQ_W-1:0]        nx;
  logic [hbs_pkg::GQ_W-1:0]        nz;
  logic [PXW-1:0]                  px;
  logic [hbs_pkg::FX_W-1:0]        wdata;
  logic [1:0]                      k1;
  logic [hbs_pkg::IDX_W-1:0]       col1;
  logic [hbs_pkg::IDX_W-1:0]       row1;
  logic [hbs_pkg::RES_W-1:0]       xi;
  logic [hbs_pkg::RES_W-1:0]       zi;
  logic [hbs_pkg::RES_W-1:0]       x0;
  logic [hbs_pkg::RES_W-1:0]       x1;
  logic [hbs_pkg::RES_W-1:0]       z0;
  logic [hbs_pkg::RES_W-1:0]       z1;
  logic                            we;
  logic [1:0]                      wbank;
  logic [BAW-1:0]                  waddr;
  logic [BAW-1:0]                  raddr [4];
  logic [hbs_pkg::FX_W-1:0]        rdata [4];

  // s2: corner parities and fractions beside the RAM read data
  logic                            v2_r;
  logic [1:0]                      k2_r;
  logic [15:0]                     tx2_r;
  logic [15:0]                     tz2_r;
  logic                            x0p_r;
  logic                            x1p_r;
  logic                            z0p_r;
  logic                            z1p_r;
  logic [hbs_pkg::FX_W-1:0]        h00;
  logic [hbs_pkg::FX_W-1:0]        h10;
  logic [hbs_pkg::FX_W-1:0]        h01;
  logic [hbs_pkg::FX_W-1:0]        h11;

  // s3: corner bases and differences
  logic                            v3_r;
  logic [1:0]                      k3_r;
  logic signed [31:0]              a0_3_r;
  logic signed [31:0]              a1_3_r;
  logic signed [32:0]              d0_r;
  logic signed [32:0]              d1_r;
  logic signed [16:0]              tx3_r;
  logic [15:0]                     tz3_r;
  logic signed [49:0]              p0;
  logic signed [49:0]              p1;

  // s4: x-blend products
  logic                            v4_r;
  logic [1:0]                      k4_r;
  logic signed [31:0]              a0_4_r;
  logic signed [31:0]              a1_4_r;
  logic signed [49:0]              p0_r;
  logic signed [49:0]              p1_r;
  logic [15:0]                     tz4_r;
  logic signed [31:0]              hx0;
  logic signed [31:0]              hx1;

  // s5: z-blend inputs
  logic                            v5_r;
  logic [1:0]                      k5_r;
  logic signed [31:0]              hx0_5_r;
  logic signed [32:0]              dz_r;
  logic signed [16:0]              tz5_r;
  logic signed [49:0]              pz;

  // s6: z-blend product
  logic                            v6_r;
  logic [1:0]                      k6_r;
  logic signed [31:0]              hx0_6_r;
  logic signed [49:0]              pz_r;
  logic signed [31:0]              hfin;

  logic                            out_valid_r;
  logic [hbs_pkg::FX_W-1:0]        out_height_r;
  logic                            out_hit_r;

  assign be    = !out_valid_r || out_ready;
  assign q_pop = be && !q_empty;

  assign size_eff = (chunk_size < hbs_pkg::SIZE_W'(hbs_pkg::ONE_FX)) ?
                    hbs_pkg::ONE_FX : {1'b0, chunk_size};

  always_comb begin
    if (grid_resolution < 7'd2) begin
      resm1 = 7'd1;
    end else if (32'(grid_resolution) > MAX_GRID) begin
      resm1 = hbs_pkg::RES_W'(MAX_GRID - 1);
    end else begin
      resm1 = grid_resolution - 7'd1;
    end
  end

  // ---- s0 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (be) begin
      v0_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      k0_r   <= q_head.kind;
      col0_r <= q_head.col;
      row0_r <= q_head.row;
      hgt0_r <= q_head.height;
      mx_r   <= hbs_pkg::M_W'(q_head.lx) * hbs_pkg::M_W'(resm1);
      mz_r   <= hbs_pkg::M_W'(q_head.lz) * hbs_pkg::M_W'(resm1);
    end
  end

  // ---- grid position: floor(m * 65536 / size) ----
  hbs_div #(.QW(hbs_pkg::GQ_W), .PW(PXW)) u_divx (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (be),
    .i_vld   (v0_r),
    .i_rem   (32'(mx_r[hbs_pkg::M_W-1:7])),
    .i_bits  ({mx_r[6:0], 16'd0}),
    .i_pay   ({k0_r, col0_r, row0_r}),
    .divisor (size_eff),
    .o_vld   (vx),
    .o_quo   (nx),
    .o_rem   (),
    .o_pay   (px)
  );

  hbs_div #(.QW(hbs_pkg::GQ_W), .PW(hbs_pkg::FX_W)) u_divz (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (be),
    .i_vld   (v0_r),
    .i_rem   (32'(mz_r[hbs_pkg::M_W-1:7])),
    .i_bits  ({mz_r[6:0], 16'd0}),
    .i_pay   (hgt0_r),
    .divisor (size_eff),
    .o_vld   (vz),
    .o_quo   (nz),
    .o_rem   (),
    .o_pay   (wdata)
  );

  // ---- s1: cell indices, clamped neighbours, store access ----
  assign k1   = px[PXW-1:PXW-2];
  assign col1 = px[2*hbs_pkg::IDX_W-1:hbs_pkg::IDX_W];
  assign row1 = px[hbs_pkg::IDX_W-1:0];
  assign xi   = nx[hbs_pkg::GQ_W-1:16];
  assign zi   = nz[hbs_pkg::GQ_W-1:16];
  assign x0   = (xi > resm1) ? resm1 : xi;
  assign z0   = (zi > resm1) ? resm1 : zi;
  assign x1   = (x0 == resm1) ? x0 : x0 + 7'd1;
  assign z1   = (z0 == resm1) ? z0 : z0 + 7'd1;

  // Banks by row and column parity: the four corners always land in
  // distinct banks, or share one index when clamped.
  assign we    = vx && be && (k1 == hbs_pkg::KIND_WR) &&
                 (32'(col1) < MAX_GRID) && (32'(row1) < MAX_GRID);
  assign wbank = {row1[0], col1[0]};
  assign waddr = BAW'(32'(row1 >> 1) * HALF + 32'(col1 >> 1));

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      raddr[b] = BAW'(32'(((z0[0] == b[1]) ? z0 : z1) >> 1) * HALF +
                      32'(((x0[0] == b[0]) ? x0 : x1) >> 1));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    hbs_ram #(.W(hbs_pkg::FX_W), .DEPTH(BDEPTH)) u_ram (
      .clk   (clk),
      .we    (we && (wbank == 2'(b))),
      .waddr (waddr),
      .wdata (wdata),
      .re    (be),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  // ---- s2 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (be) begin
      v2_r <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      k2_r  <= k1;
      tx2_r <= nx[15:0];
      tz2_r <= nz[15:0];
      x0p_r <= x0[0];
      x1p_r <= x1[0];
      z0p_r <= z0[0];
      z1p_r <= z1[0];
    end
  end

  assign h00 = rdata[{z0p_r, x0p_r}];
  assign h10 = rdata[{z0p_r, x1p_r}];
  assign h01 = rdata[{z1p_r, x0p_r}];
  assign h11 = rdata[{z1p_r, x1p_r}];

  // ---- s3 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (be) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      k3_r   <= k2_r;
      a0_3_r <= h00;
      a1_3_r <= h01;
      d0_r   <= {h10[31], h10} - {h00[31], h00};
      d1_r   <= {h11[31], h11} - {h01[31], h01};
      tx3_r  <= {1'b0, tx2_r};
      tz3_r  <= tz2_r;
    end
  end

  assign p0 = d0_r * tx3_r;
  assign p1 = d1_r * tx3_r;

  // ---- s4 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (be) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      k4_r   <= k3_r;
      a0_4_r <= a0_3_r;
      a1_4_r <= a1_3_r;
      p0_r   <= p0;
      p1_r   <= p1;
      tz4_r  <= tz3_r;
    end
  end

  // the blended value lies between its corners, so 32 bits hold it
  assign hx0 = a0_4_r + p0_r[47:16];
  assign hx1 = a1_4_r + p1_r[47:16];

  // ---- s5 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (be) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      k5_r    <= k4_r;
      hx0_5_r <= hx0;
      dz_r    <= {hx1[31], hx1} - {hx0[31], hx0};
      tz5_r   <= {1'b0, tz4_r};
    end
  end

  assign pz = dz_r * tz5_r;

  // ---- s6 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (be) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      k6_r    <= k5_r;
      hx0_6_r <= hx0_5_r;
      pz_r    <= pz;
    end
  end

  assign hfin = hx0_6_r + pz_r[47:16];

  // ---- output register: writes drop out here ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (be) begin
      out_valid_r <= v6_r && (k6_r != hbs_pkg::KIND_WR);
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_hit_r    <= (k6_r == hbs_pkg::KIND_HIT);
      out_height_r <= (k6_r == hbs_pkg::KIND_HIT) ? hfin : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;
  assign out_hit    = out_hit_r;

  a_grid_lockstep: assert property (@(posedge clk) disable iff (!rst_n) vx == vz)
    else $error("x and z grid dividers out of step");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_hit_r |-> out_height_r == '0)
    else $error("missed query carries a nonzero height");
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
      be && v6_r && (k6_r == hbs_pkg::KIND_WR) |=> !out_valid_r)
    else $error("height write produced a result");

endmodule

`default_nettype wire

// ===== sv/heightfield_bilinear_sampler.sv =====
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler: bilinear height lookup on one terrain tile
// Holds a tile's height grid and answers interpolated height queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one word per item. in_tuser selects the operation: 0 writes
//   one grid height (no result), 1 queries a world position (one result).
//   out_* returns one word per query: the Q16.16 height and a hit flag.
//   cfg_* writes the tile registers; write them only while no item is in
//   flight.
// Throughput: one word per cycle on both sides when the receiver keeps up.
// Pipeline: between the input accept and the earliest result accept an item passes
//   16 divider stages for the chunk index, one queue slot, one scaling stage,
//   23 divider stages for the grid position, one banked store read, four
//   blend stages and the output register.
// Stalls: the result sits in an output register; while out_tready is low the
//   back end holds, the queue between front and back fills, and in_tready
//   drops once the queue is full. No word is lost or repeated.
// Reset: registers take their default values (tile absent, 64 samples,
//   32.0 world units per tile); the height grid holds nothing until written,
//   and each entry must be written before a query reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_bilinear_sampler #(
  parameter int MAX_GRID = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input words
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // grid_col[5:0], grid_row[11:6], height_in[43:12], world_x[75:44],
  // world_z[107:76], zero pad [111:108]
  input  wire logic [111:0]                in_tdata,
  // func[0]
  input  wire logic [0:0]                  in_tuser,
  // result words
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // height_out[31:0]
  output logic [31:0]                      out_tdata,
  // hit_valid[0]
  output logic [0:0]                       out_tuser,
  // register writes
  input  wire logic                        cfg_we,
  input  wire logic [hbs_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [30:0]                 cfg_wdata
);

  logic [hbs_pkg::SIZE_W-1:0] chunk_size_r;
  logic [hbs_pkg::SIZE_W-1:0] chunk_size_nxt;
  logic [hbs_pkg::RES_W-1:0]  grid_res_r;
  logic [hbs_pkg::RES_W-1:0]  grid_res_nxt;
  logic [hbs_pkg::TILE_W-1:0] tile_x_r;
  logic [hbs_pkg::TILE_W-1:0] tile_x_nxt;
  logic [hbs_pkg::TILE_W-1:0] tile_z_r;
  logic [hbs_pkg::TILE_W-1:0] tile_z_nxt;
  logic                       present_r;
  logic                       present_nxt;

  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  hbs_pkg::qent_t             q_in;
  hbs_pkg::qent_t             q_head;

  // register file: decode the index, ignore indexes past the list
  always_comb begin
    chunk_size_nxt = chunk_size_r;
    grid_res_nxt   = grid_res_r;
    tile_x_nxt     = tile_x_r;
    tile_z_nxt     = tile_z_r;
    present_nxt    = present_r;
    if (cfg_we) begin
      case (cfg_addr)
        hbs_pkg::CFG_CHUNK_SIZE: chunk_size_nxt = cfg_wdata;
        hbs_pkg::CFG_GRID_RES:   grid_res_nxt   = cfg_wdata[hbs_pkg::RES_W-1:0];
        hbs_pkg::CFG_TILE_X:     tile_x_nxt     = cfg_wdata[hbs_pkg::TILE_W-1:0];
        hbs_pkg::CFG_TILE_Z:     tile_z_nxt     = cfg_wdata[hbs_pkg::TILE_W-1:0];
        hbs_pkg::CFG_PRESENT:    present_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= 31'h0020_0000;
      grid_res_r   <= 7'd64;
      tile_x_r     <= '0;
      tile_z_r     <= '0;
      present_r    <= 1'b0;
    end else begin
      chunk_size_r <= chunk_size_nxt;
      grid_res_r   <= grid_res_nxt;
      tile_x_r     <= tile_x_nxt;
      tile_z_r     <= tile_z_nxt;
      present_r    <= present_nxt;
    end
  end

  // front: chunk index, tile match, local offset
  hbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .func         (in_tuser[0]),
    .grid_col     (in_tdata[5:0]),
    .grid_row     (in_tdata[11:6]),
    .height_in    (in_tdata[43:12]),
    .world_x      (in_tdata[75:44]),
    .world_z      (in_tdata[107:76]),
    .chunk_size   (chunk_size_r),
    .tile_chunk_x (tile_x_r),
    .tile_chunk_z (tile_z_r),
    .tile_present (present_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ent        (q_in)
  );

  // decouple the two halves so each stalls on its own
  hbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: grid position, corner reads, blend, result register
  hbs_back #(.MAX_GRID(MAX_GRID)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .chunk_size      (chunk_size_r),
    .grid_resolution (grid_res_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_height      (out_tdata),
    .out_hit         (out_tuser[0])
  );

endmodule

`default_nettype wire
